/* sv/ivss_pkg.sv */
// Shared types and constants for the int64 vector store with search.
// No dependencies; used by ivss_ctrl, ivss_dp and the top level.
`default_nettype none

package ivss_pkg;

    localparam int MODE_W       = 3;
    localparam int POS_W        = 10;
    localparam int DATA_W       = 64;
    localparam int STAT_W       = 2;
    localparam int IDX_W        = 10;
    localparam int FILL_W       = 11;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_GET    = 3'd2,
        MODE_SET    = 3'd3,
        MODE_CLEAR  = 3'd4,
        MODE_SEARCH = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    // what the output register is loaded with
    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_MISS,
        RES_VALUE,
        RES_HIT
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic latch;
        logic do_push;
        logic do_pop;
        logic do_get;
        logic do_set;
        logic do_clear;
        logic srch_start;
        logic srch_step;
        logic out_load;
        res_t res;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  in_range;
        logic  hit;
        logic  exhausted;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

/* sv/ivss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ivss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/ivss_ctrl.sv */
// Controller state machine: sequences each item and loads the result.
// Depends on ivss_pkg.
`default_nettype none

module ivss_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ivss_pkg::sts_t sts,
    output ivss_pkg::cmd_t     cmd
);

    ivss_pkg::state_t state_reg;
    ivss_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ivss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = ivss_pkg::RES_OK;
        s_ready    = 1'b0;
        unique case (state_reg)
            ivss_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ivss_pkg::ST_EXEC;
                end
            end
            ivss_pkg::ST_EXEC: begin
                unique case (sts.mode)
                    ivss_pkg::MODE_PUSH: begin
                        if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            if (sts.full) begin
                                cmd.res = ivss_pkg::RES_FULL;
                            end else begin
                                cmd.do_push = 1'b1;
                            end
                            state_next = ivss_pkg::ST_IDLE;
                        end
                    end
                    ivss_pkg::MODE_POP: begin
                        if (!sts.empty) begin
                            cmd.do_pop = 1'b1;
                            state_next = ivss_pkg::ST_READ;
                        end else if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.res      = ivss_pkg::RES_MISS;
                            state_next   = ivss_pkg::ST_IDLE;
                        end
                    end
                    ivss_pkg::MODE_GET: begin
                        if (sts.in_range) begin
                            cmd.do_get = 1'b1;
                            state_next = ivss_pkg::ST_READ;
                        end else if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.res      = ivss_pkg::RES_MISS;
                            state_next   = ivss_pkg::ST_IDLE;
                        end
                    end
                    ivss_pkg::MODE_SET: begin
                        if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            if (sts.in_range) begin
                                cmd.do_set = 1'b1;
                            end else begin
                                cmd.res = ivss_pkg::RES_MISS;
                            end
                            state_next = ivss_pkg::ST_IDLE;
                        end
                    end
                    ivss_pkg::MODE_CLEAR: begin
                        if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.do_clear = 1'b1;
                            state_next   = ivss_pkg::ST_IDLE;
                        end
                    end
                    ivss_pkg::MODE_SEARCH: begin
                        if (!sts.empty) begin
                            cmd.srch_start = 1'b1;
                            state_next     = ivss_pkg::ST_SEARCH;
                        end else if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.res      = ivss_pkg::RES_MISS;
                            state_next   = ivss_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ivss_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            ivss_pkg::ST_READ: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res      = ivss_pkg::RES_VALUE;
                    state_next   = ivss_pkg::ST_IDLE;
                end
            end
            ivss_pkg::ST_SEARCH: begin
                priority if (sts.hit) begin
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.res      = ivss_pkg::RES_HIT;
                        state_next   = ivss_pkg::ST_IDLE;
                    end
                end else if (sts.exhausted) begin
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.res      = ivss_pkg::RES_MISS;
                        state_next   = ivss_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.srch_step = 1'b1;
                end
            end
            default: begin
                state_next = ivss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/ivss_dp.sv */
// Datapath: item registers, element count, search bounds, store and result register.
// Depends on ivss_pkg and ivss_ram.
`default_nettype none

module ivss_dp #(
    parameter int CAPACITY = ivss_pkg::CAPACITY_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ivss_pkg::MODE_W-1:0]   s_mode,
    input  wire logic [ivss_pkg::POS_W-1:0]    s_position,
    input  wire logic signed [ivss_pkg::DATA_W-1:0] s_operand,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ivss_pkg::STAT_W-1:0]        m_status,
    output logic [ivss_pkg::IDX_W-1:0]         m_found_index,
    output logic signed [ivss_pkg::DATA_W-1:0] m_read_value,
    output logic [ivss_pkg::FILL_W-1:0]        m_fill_level,
    input  wire ivss_pkg::cmd_t                cmd,
    output ivss_pkg::sts_t                     sts
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ivss_pkg::POS_W) ? CW : ivss_pkg::POS_W;
    localparam int DW = ivss_pkg::DATA_W;

    ivss_pkg::mode_t             mode_reg;
    logic [ivss_pkg::POS_W-1:0]  pos_reg;
    logic [DW-1:0]               opnd_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic signed [CW:0]          lo_reg;
    logic signed [CW:0]          hi_reg;
    logic [AW-1:0]               mid_reg;
    logic                        m_valid_reg;
    ivss_pkg::status_t           status_reg;
    logic [ivss_pkg::IDX_W-1:0]  idx_reg;
    logic [DW-1:0]               value_reg;
    logic [ivss_pkg::FILL_W-1:0] fill_reg;

    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [CW-1:0]      cnt_m1;
    logic signed [CW:0] hi0;
    logic [AW-1:0]      mid0;
    logic signed [CW:0] mid_x;
    logic               key_less;
    logic signed [CW:0] lo_n;
    logic signed [CW:0] hi_n;
    logic [CW:0]        sum_n;
    logic [AW-1:0]      mid_n;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    assign pos_x    = XW'(pos_reg);
    assign cnt_x    = XW'(count_reg);
    assign cnt_m1   = count_reg - CW'(1);
    assign hi0      = $signed((CW + 1)'(count_reg)) - $signed((CW + 1)'(1));
    assign mid0     = hi0[AW:1];
    assign mid_x    = $signed((CW + 1)'(mid_reg));
    assign key_less = $signed(ram_rdata) < $signed(opnd_reg);
    assign lo_n     = key_less ? (mid_x + $signed((CW + 1)'(1))) : lo_reg;
    assign hi_n     = key_less ? hi_reg : (mid_x - $signed((CW + 1)'(1)));
    assign sum_n    = $unsigned(lo_n) + $unsigned(hi_n);
    assign mid_n    = sum_n[AW:1];

    always_comb begin
        sts           = '0;
        sts.mode      = mode_reg;
        sts.full      = (count_reg == CW'(CAPACITY));
        sts.empty     = (count_reg == '0);
        sts.in_range  = (pos_x < cnt_x);
        sts.hit       = (ram_rdata == opnd_reg);
        sts.exhausted = (lo_n > hi_n);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        ram_we    = cmd.do_push || cmd.do_set;
        ram_waddr = cmd.do_push ? count_reg[AW-1:0] : pos_x[AW-1:0];
        ram_re    = cmd.do_pop || cmd.do_get || cmd.srch_start || cmd.srch_step;
        priority if (cmd.do_pop) begin
            ram_raddr = cnt_m1[AW-1:0];
        end else if (cmd.do_get) begin
            ram_raddr = pos_x[AW-1:0];
        end else if (cmd.srch_start) begin
            ram_raddr = mid0;
        end else begin
            ram_raddr = mid_n;
        end
    end

    ivss_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (opnd_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        count_next = count_reg;
        priority if (cmd.do_clear) begin
            count_next = '0;
        end else if (cmd.do_push) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.do_pop) begin
            count_next = cnt_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            mode_reg <= ivss_pkg::mode_t'(s_mode);
            pos_reg  <= s_position;
            opnd_reg <= s_operand;
        end
        if (cmd.srch_start) begin
            lo_reg  <= '0;
            hi_reg  <= hi0;
            mid_reg <= mid0;
        end else if (cmd.srch_step) begin
            lo_reg  <= lo_n;
            hi_reg  <= hi_n;
            mid_reg <= mid_n;
        end
        if (cmd.out_load) begin
            unique case (cmd.res)
                ivss_pkg::RES_FULL: status_reg <= ivss_pkg::STAT_FULL;
                ivss_pkg::RES_MISS: status_reg <= ivss_pkg::STAT_MISS;
                default:            status_reg <= ivss_pkg::STAT_OK;
            endcase
            idx_reg   <= (cmd.res == ivss_pkg::RES_HIT) ? ivss_pkg::IDX_W'(mid_reg) : '0;
            value_reg <= (cmd.res == ivss_pkg::RES_VALUE) ? ram_rdata : '0;
            fill_reg  <= ivss_pkg::FILL_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_index = idx_reg;
    assign m_read_value  = value_reg;
    assign m_fill_level  = fill_reg;

endmodule

`default_nettype wire

/* sv/int64_vector_store_with_search_unit.sv */
// Top level of the int64 vector store with search.
// Depends on ivss_pkg, ivss_ctrl, ivss_dp (which holds ivss_ram).
//
// Usage:
//   Input channel s_*: mode, position, operand; one item is taken at an edge
//   with s_valid and s_ready high. Result channel m_*: status, found_index,
//   read_value, fill_level; one result per item, held until m_ready.
//   Items are worked one at a time. s_ready is high whenever no item is in
//   work, also while the previous result still waits in the output register.
//   Push, set, clear, unused modes and misses found without a store read
//   load the result in the execute state; pop and get first do one
//   registered read of the element store; search runs P probes with
//   P <= clog2(CAPACITY) + 1, one store read per probe, the compare and
//   next-probe address in the same cycle. Each item is accepted in the idle
//   state. If the receiver stalls, the next item is still taken, but its
//   result load waits for the result register to free; push, set and clear
//   commit together with that load.
//   Reset clears the element count and all handshake state; store contents are
//   not cleared and need not be, since only entries below the count are read.
`default_nettype none

module int64_vector_store_with_search_unit #(
    parameter int CAPACITY = ivss_pkg::CAPACITY_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ivss_pkg::MODE_W-1:0]         s_mode,
    input  wire logic [ivss_pkg::POS_W-1:0]          s_position,
    input  wire logic signed [ivss_pkg::DATA_W-1:0]  s_operand,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ivss_pkg::STAT_W-1:0]              m_status,
    output logic [ivss_pkg::IDX_W-1:0]               m_found_index,
    output logic signed [ivss_pkg::DATA_W-1:0]       m_read_value,
    output logic [ivss_pkg::FILL_W-1:0]              m_fill_level
);

    ivss_pkg::cmd_t cmd;
    ivss_pkg::sts_t sts;

    ivss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ivss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_mode        (s_mode),
        .s_position    (s_position),
        .s_operand     (s_operand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_read_value  (m_read_value),
        .m_fill_level  (m_fill_level),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

/* dv/ivss_check_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the int64 vector store with search: mirrors the element store and
// length, predicts one outcome per accepted item and checks the results in order.
// Depends on ivss_pkg.

package ivss_check_pkg;
    import ivss_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic [IDX_W-1:0]         found_index;
        logic signed [DATA_W-1:0] read_value;
        logic [FILL_W-1:0]        fill_level;
    } outcome_t;

    class vector_store_scoreboard;
        logic signed [DATA_W-1:0] elements [CAPACITY_DEF];
        int unsigned              length;
        outcome_t                 outcomes_due [$];
        int unsigned              errors;

        function new();
            length = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return outcomes_due.size();
        endfunction

        function logic signed [DATA_W-1:0] element(int unsigned at);
            return elements[at];
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                                logic signed [DATA_W-1:0] operand);
            outcome_t o;
            int lo;
            int hi;
            int mid;
            o.status      = STAT_OK;
            o.found_index = '0;
            o.read_value  = '0;
            case (mode)
                MODE_PUSH: begin
                    if (length >= CAPACITY_DEF) begin
                        o.status = STAT_FULL;
                    end else begin
                        elements[length] = operand;
                        length++;
                    end
                end
                MODE_POP: begin
                    if (length == 0) begin
                        o.status = STAT_MISS;
                    end else begin
                        length--;
                        o.read_value = elements[length];
                    end
                end
                MODE_GET: begin
                    if (position >= length) o.status = STAT_MISS;
                    else o.read_value = elements[position];
                end
                MODE_SET: begin
                    if (position >= length) o.status = STAT_MISS;
                    else elements[position] = operand;
                end
                MODE_CLEAR: length = 0;
                MODE_SEARCH: begin
                    lo = 0;
                    hi = int'(length) - 1;
                    o.status = STAT_MISS;
                    while (lo <= hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (elements[mid] == operand) begin
                            o.status      = STAT_OK;
                            o.found_index = mid[IDX_W-1:0];
                            break;
                        end
                        if (elements[mid] < operand) lo = mid + 1;
                        else hi = mid - 1;
                    end
                end
                default: ;
            endcase
            o.fill_level = length[FILL_W-1:0];
            outcomes_due.push_back(o);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] found_index,
                                   logic signed [DATA_W-1:0] read_value,
                                   logic [FILL_W-1:0] fill_level);
            outcome_t want;
            if (outcomes_due.size() == 0) begin
                $error("result with no item outstanding: status %0d fill_level %0d",
                       status, fill_level);
                errors++;
                return;
            end
            want = outcomes_due.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (found_index !== want.found_index) begin
                $error("found_index: expected %0d, got %0d", want.found_index, found_index);
                errors++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %h, got %h", want.read_value, read_value);
                errors++;
            end
            if (fill_level !== want.fill_level) begin
                $error("fill_level: expected %0d, got %0d", want.fill_level, fill_level);
                errors++;
            end
        endfunction
    endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top-level testbench for int64_vector_store_with_search_unit: directed corner items,
// a fill to capacity, then sorted-store search sessions mixed with random noise.
// Depends on ivss_pkg, ivss_check_pkg and the unit RTL.

module testbench;
    import ivss_pkg::*;
    import ivss_check_pkg::*;

    localparam int TOTAL_ITEMS  = 1250;
    localparam int DRAIN_CYCLES = 40;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [MODE_W-1:0]         s_mode = '0;
    logic [POS_W-1:0]          s_position = '0;
    logic signed [DATA_W-1:0]  s_operand = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [STAT_W-1:0]         m_status;
    logic [IDX_W-1:0]          m_found_index;
    logic signed [DATA_W-1:0]  m_read_value;
    logic [FILL_W-1:0]         m_fill_level;

    vector_store_scoreboard sb = new();
    bit                     tx_steady = 1'b0;
    bit                     rx_steady = 1'b0;
    int unsigned            items_sent = 0;

    int64_vector_store_with_search_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_position    (s_position),
        .s_operand     (s_operand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_read_value  (m_read_value),
        .m_fill_level  (m_fill_level)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("int64_vector_store_with_search_unit regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_found_index, m_read_value, m_fill_level);
    end

    // result side: random stall before each result, none while rx_steady is set
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly in range when the store holds anything
    function automatic logic [POS_W-1:0] pick_position();
        if (sb.length > 0 && $urandom_range(0, 3) != 0)
            return POS_W'($urandom_range(0, sb.length - 1));
        return POS_W'($urandom_range(0, CAPACITY_DEF - 1));
    endfunction

    function automatic logic signed [DATA_W-1:0] stored_key();
        if (sb.length == 0) return rand_word();
        return sb.element($urandom_range(0, sb.length - 1));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                             logic signed [DATA_W-1:0] operand);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_position <= position;
        s_operand  <= operand;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(mode, position, operand);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic push_sorted(int count, bit narrow);
        longint vals [$];
        repeat (count) begin
            if (narrow) vals.push_back(longint'($urandom_range(0, 40)) - 20);
            else vals.push_back(longint'(rand_word()));
        end
        vals.sort();
        foreach (vals[i]) send_item(MODE_PUSH, pick_position(), vals[i]);
    endtask

    task automatic fill_to_capacity();
        send_item(MODE_CLEAR, pick_position(), rand_word());
        push_sorted(CAPACITY_DEF, 1'b0);
        send_item(MODE_PUSH, pick_position(), rand_word());
        send_item(MODE_GET, POS_W'(CAPACITY_DEF - 1), rand_word());
        repeat (6) send_item(MODE_SEARCH, pick_position(), stored_key());
        send_item(MODE_SEARCH, pick_position(), stored_key() + 1);
        send_item(MODE_SET, POS_W'(CAPACITY_DEF - 1), rand_word());
        send_item(MODE_POP, pick_position(), rand_word());
        send_item(MODE_PUSH, pick_position(), rand_word());
        send_item(MODE_PUSH, pick_position(), rand_word());
    endtask

    task automatic sorted_session();
        int ops;
        send_item(MODE_CLEAR, pick_position(), rand_word());
        push_sorted($urandom_range(1, 48), $urandom_range(0, 3) == 0);
        ops = $urandom_range(4, 16);
        repeat (ops) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_item(MODE_SEARCH, pick_position(), stored_key());
                4: send_item(MODE_SEARCH, pick_position(), stored_key() + 1);
                5: send_item(MODE_SEARCH, pick_position(), rand_word());
                6: send_item(MODE_GET, pick_position(), rand_word());
                7: send_item(MODE_SET, pick_position(), rand_word());
                8: send_item(MODE_POP, pick_position(), rand_word());
                default: send_item(MODE_PUSH, pick_position(), rand_word());
            endcase
        end
    endtask

    task automatic noise_burst();
        int ops;
        ops = $urandom_range(3, 20);
        repeat (ops) begin
            send_item(MODE_W'($urandom_range(0, 7)), pick_position(),
                      $urandom_range(0, 1) ? stored_key() : rand_word());
        end
    endtask

    initial begin : stimulus
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(MODE_POP, '0, '0);
        send_item(MODE_GET, '0, '0);
        send_item(MODE_SET, '0, rand_word());
        send_item(MODE_SEARCH, '0, '0);
        send_item(MODE_SPARE_LO, '1, '1);
        send_item(MODE_SPARE_HI, '0, '0);
        send_item(MODE_PUSH, '0, 64'sh7fff_ffff_ffff_ffff);
        send_item(MODE_PUSH, '0, 64'sh8000_0000_0000_0000);
        send_item(MODE_PUSH, '0, '0);
        send_item(MODE_PUSH, '0, '1);
        send_item(MODE_GET, 10'd0, '0);
        send_item(MODE_GET, 10'd3, '0);
        send_item(MODE_GET, 10'd4, '0);
        send_item(MODE_GET, '1, '0);
        send_item(MODE_SET, 10'd1, 64'sh5555_5555_5555_5555);
        send_item(MODE_SET, '1, 64'sh2aaa_aaaa_aaaa_aaaa);
        send_item(MODE_SEARCH, '0, '0);
        send_item(MODE_SEARCH, '0, 64'sh7fff_ffff_ffff_ffff);
        send_item(MODE_SEARCH, '0, '1);
        send_item(MODE_SPARE_HI, '0, '1);
        send_item(MODE_POP, '0, '0);
        send_item(MODE_CLEAR, '1, '1);
        send_item(MODE_POP, '0, '0);
        wait_drained();

        fill_to_capacity();
        wait_drained();

        while (items_sent < TOTAL_ITEMS) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) sorted_session();
            else noise_burst();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("int64_vector_store_with_search_unit regression: pass");
        end else begin
            $display("int64_vector_store_with_search_unit regression: fail");
        end
        $finish;
    end

endmodule
